[rtl/lpt_pkg.sv]
// Package of the laser plane triangulation unit: types, register indexes and constants.
package lpt_pkg;

   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 48;
   localparam int COORD_W      = 48;
   localparam int DEN_W        = 84;
   localparam int DMAG_W       = 83;
   localparam int PROD_W       = 97;
   localparam int QUO_W        = 48;
   localparam int FEED_BITS    = 18;
   localparam int NORM_SHIFT   = 30;
   localparam int LANES        = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_NX     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_NY     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_NZ     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_OFFSET = 3'd7;

   localparam logic [1:0] STATUS_VALID     = 2'd0;
   localparam logic [1:0] STATUS_PARALLEL  = 2'd1;
   localparam logic [1:0] STATUS_BEHIND    = 2'd2;
   localparam logic [1:0] STATUS_SATURATED = 2'd3;

   localparam logic [QUO_W-1:0] LIM_POS = 48'h7FFF_FFFF_FFFF;
   localparam logic [QUO_W-1:0] LIM_NEG = 48'h8000_0000_0000;

   localparam int LANE_X = 0;
   localparam int LANE_Y = 1;
   localparam int LANE_Z = 2;

   typedef struct packed {
      logic [23:0] pixel_col;
      logic [23:0] pixel_row;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [47:0]  point_x;
      logic signed [47:0]  point_y;
      logic signed [47:0]  point_z;
   } rsp_type;

   typedef struct packed {
      logic [23:0]         focal_x;
      logic [23:0]         focal_y;
      logic [23:0]         center_x;
      logic [23:0]         center_y;
      logic signed [31:0]  plane_nx;
      logic signed [31:0]  plane_ny;
      logic signed [31:0]  plane_nz;
      logic signed [47:0]  plane_offset;
   } cfg_type;

   // One coordinate in the divider: partial remainder, and a shift word that
   // feeds numerator bits out the top while quotient bits enter the bottom.
   typedef struct packed {
      logic [DMAG_W-1:0] rem;
      logic [QUO_W-1:0]  sh;
      logic              big;
      logic              flip;
   } lane_type;

   typedef struct packed {
      logic                        valid;
      logic                        dzero;
      logic [DMAG_W-1:0]           dmag;
      lane_type [LANES-1:0]        lane;
   } div_type;

endpackage

[rtl/lpt_front.sv]
// Front end: ray direction, plane denominator and numerators, divider setup (four stages).
module lpt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_valid,
   input  lpt_pkg::req_type  req_data,
   input  lpt_pkg::cfg_type  cfg,
   output lpt_pkg::div_type  div_out
);

   // Stage 1: direction terms mx, my, mz.
   logic                     s1_valid_ff;
   logic signed [49:0]       s1_m_ff [lpt_pkg::LANES];
   logic signed [24:0]       dx, dy;
   logic signed [49:0]       dx_w, dy_w, fx_w, fy_w;
   logic [47:0]              fxy;
   logic signed [49:0]       s1_m_in [lpt_pkg::LANES];

   always_comb begin
      dx = $signed({1'b0, req_data.pixel_col}) - $signed({1'b0, cfg.center_x});
      dy = $signed({1'b0, req_data.pixel_row}) - $signed({1'b0, cfg.center_y});
      dx_w = 50'(dx);
      dy_w = 50'(dy);
      fx_w = $signed({26'd0, cfg.focal_x});
      fy_w = $signed({26'd0, cfg.focal_y});
      fxy = 48'(cfg.focal_x) * 48'(cfg.focal_y);
      s1_m_in[lpt_pkg::LANE_X] = dx_w * fy_w;
      s1_m_in[lpt_pkg::LANE_Y] = dy_w * fx_w;
      s1_m_in[lpt_pkg::LANE_Z] = $signed({2'b00, fxy});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
      if (advance) begin
         s1_m_ff <= s1_m_in;
      end
   end

   // Stage 2: partial products of the denominator and of the numerator magnitudes.
   logic                     s2_valid_ff;
   logic signed [57:0]       s2_pl_ff [lpt_pkg::LANES];
   logic signed [56:0]       s2_ph_ff [lpt_pkg::LANES];
   logic [47:0]              s2_hh_ff [lpt_pkg::LANES];
   logic [48:0]              s2_hl_ff [lpt_pkg::LANES];
   logic [47:0]              s2_lh_ff [lpt_pkg::LANES];
   logic [48:0]              s2_ll_ff [lpt_pkg::LANES];
   logic                     s2_mneg_ff [lpt_pkg::LANES];
   logic signed [31:0]       nrm [lpt_pkg::LANES];
   logic [47:0]              dmag_d;
   logic signed [49:0]       mneg_v [lpt_pkg::LANES];
   logic [48:0]              ma [lpt_pkg::LANES];

   always_comb begin
      nrm[lpt_pkg::LANE_X] = cfg.plane_nx;
      nrm[lpt_pkg::LANE_Y] = cfg.plane_ny;
      nrm[lpt_pkg::LANE_Z] = cfg.plane_nz;
      dmag_d = cfg.plane_offset[47] ? 48'(-cfg.plane_offset) : 48'(cfg.plane_offset);
      for (int k = 0; k < lpt_pkg::LANES; k++) begin
         mneg_v[k] = -s1_m_ff[k];
         ma[k] = s1_m_ff[k][49] ? mneg_v[k][48:0] : s1_m_ff[k][48:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         for (int k = 0; k < lpt_pkg::LANES; k++) begin
            s2_pl_ff[k] <= 58'(nrm[k]) * 58'($signed({1'b0, s1_m_ff[k][24:0]}));
            s2_ph_ff[k] <= 57'(nrm[k]) * 57'($signed(s1_m_ff[k][49:25]));
            s2_hh_ff[k] <= 48'(dmag_d[47:24]) * 48'(ma[k][48:25]);
            s2_hl_ff[k] <= 49'(dmag_d[47:24]) * 49'(ma[k][24:0]);
            s2_lh_ff[k] <= 48'(dmag_d[23:0]) * 48'(ma[k][48:25]);
            s2_ll_ff[k] <= 49'(dmag_d[23:0]) * 49'(ma[k][24:0]);
            s2_mneg_ff[k] <= s1_m_ff[k][49];
         end
      end
   end

   // Stage 3: sums of the partial products.
   logic                               s3_valid_ff;
   logic signed [lpt_pkg::DEN_W-1:0]   s3_den_ff;
   logic [lpt_pkg::PROD_W-1:0]         s3_prod_ff [lpt_pkg::LANES];
   logic                               s3_mneg_ff [lpt_pkg::LANES];
   logic signed [lpt_pkg::DEN_W-1:0]   den_in;

   always_comb begin
      den_in = '0;
      for (int k = 0; k < lpt_pkg::LANES; k++) begin
         den_in = den_in + (lpt_pkg::DEN_W'(s2_ph_ff[k]) <<< 25)
                         + lpt_pkg::DEN_W'(s2_pl_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_den_ff <= den_in;
         for (int k = 0; k < lpt_pkg::LANES; k++) begin
            s3_prod_ff[k] <= (lpt_pkg::PROD_W'(s2_hh_ff[k]) << 49)
                           + (lpt_pkg::PROD_W'(s2_hl_ff[k]) << 24)
                           + (lpt_pkg::PROD_W'(s2_lh_ff[k]) << 25)
                           + lpt_pkg::PROD_W'(s2_ll_ff[k]);
            s3_mneg_ff[k] <= s2_mneg_ff[k];
         end
      end
   end

   // Stage 4: denominator magnitude, overflow check on the high quotient, divider seed.
   lpt_pkg::div_type                   div_ff, div_in;
   logic                               dneg;
   logic signed [lpt_pkg::DEN_W-1:0]   den_neg;
   logic [lpt_pkg::DMAG_W-1:0]         hi_part;

   always_comb begin
      dneg = s3_den_ff[lpt_pkg::DEN_W-1];
      den_neg = -s3_den_ff;
      div_in.valid = s3_valid_ff;
      div_in.dzero = (s3_den_ff == '0);
      div_in.dmag = dneg ? den_neg[lpt_pkg::DMAG_W-1:0] : s3_den_ff[lpt_pkg::DMAG_W-1:0];
      for (int k = 0; k < lpt_pkg::LANES; k++) begin
         hi_part = lpt_pkg::DMAG_W'(s3_prod_ff[k][lpt_pkg::PROD_W-1:lpt_pkg::FEED_BITS]);
         // A quotient of 2^48 or more only needs to be known as too big.
         div_in.lane[k].big = (hi_part >= div_in.dmag);
         div_in.lane[k].rem = div_in.lane[k].big ? '0 : hi_part;
         div_in.lane[k].sh = {s3_prod_ff[k][lpt_pkg::FEED_BITS-1:0],
                              lpt_pkg::NORM_SHIFT'(0)};
         div_in.lane[k].flip = ((cfg.plane_offset[47] == s3_mneg_ff[k]) != dneg);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (advance) begin
         div_ff.valid <= div_in.valid;
      end
      if (advance) begin
         div_ff.dzero <= div_in.dzero;
         div_ff.dmag <= div_in.dmag;
         div_ff.lane <= div_in.lane;
      end
   end

   assign div_out = div_ff;

endmodule

[rtl/lpt_div_step.sv]
// One restoring division step for all three coordinates, with its pipeline register.
module lpt_div_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  lpt_pkg::div_type  div_in,
   output lpt_pkg::div_type  div_out
);

   lpt_pkg::div_type              div_ff, nxt;
   logic [lpt_pkg::DMAG_W:0]      trial [lpt_pkg::LANES];
   logic [lpt_pkg::DMAG_W:0]      diff  [lpt_pkg::LANES];
   logic                          ge    [lpt_pkg::LANES];

   always_comb begin
      nxt = div_in;
      for (int k = 0; k < lpt_pkg::LANES; k++) begin
         trial[k] = {div_in.lane[k].rem, div_in.lane[k].sh[lpt_pkg::QUO_W-1]};
         diff[k] = trial[k] - {1'b0, div_in.dmag};
         ge[k] = (trial[k] >= {1'b0, div_in.dmag});
         nxt.lane[k].rem = ge[k] ? diff[k][lpt_pkg::DMAG_W-1:0]
                                 : trial[k][lpt_pkg::DMAG_W-1:0];
         nxt.lane[k].sh = {div_in.lane[k].sh[lpt_pkg::QUO_W-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff.valid <= 1'b0;
      end else if (advance) begin
         div_ff.valid <= nxt.valid;
      end
      if (advance) begin
         div_ff.dzero <= nxt.dzero;
         div_ff.dmag <= nxt.dmag;
         div_ff.lane <= nxt.lane;
      end
   end

   assign div_out = div_ff;

endmodule

[rtl/laser_plane_triangulation_unit.sv]
// Top level of the laser plane triangulation unit: registers, pipeline and result stage.
//
// A request carries one subpixel image point (pixel_col, pixel_row). The unit
// back-projects it through the pinhole intrinsics and intersects the ray with
// the configured light plane, returning X, Y, Z in signed Q32.16 with a status:
// valid, ray parallel to the plane, point behind the camera, or saturated.
// Every request yields exactly one response, in request order.
// The csr_ port writes one register per cycle with write enable high; the user
// must write it only while no request is in flight; the block itself does not enforce this.
// From an accepted request to its response being valid, a request passes
// four front stages (ray terms, partial products, sums, divider seed), 48
// division stages that each retire one quotient bit of all three coordinates,
// and the response register. One request per cycle is accepted while req_stall is low.
// After a synchronous reset all stages are empty and the registers hold
// their default intrinsics and plane (normal along Z, offset zero).
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
module laser_plane_triangulation_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  lpt_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output lpt_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_enable,
   input  logic [lpt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lpt_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int STEPS = lpt_pkg::QUO_W;

   // The pipeline moves whenever the response register is empty or being taken.
   logic advance;
   logic rsp_valid_ff;
   lpt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Configuration registers.
   lpt_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x <= 24'd262144;
         cfg_ff.focal_y <= 24'd262144;
         cfg_ff.center_x <= 24'd163840;
         cfg_ff.center_y <= 24'd122880;
         cfg_ff.plane_nx <= 32'sd0;
         cfg_ff.plane_ny <= 32'sd0;
         cfg_ff.plane_nz <= 32'sd1073741824;
         cfg_ff.plane_offset <= 48'sd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            lpt_pkg::CSR_FOCAL_X:      cfg_ff.focal_x <= csr_write_data[23:0];
            lpt_pkg::CSR_FOCAL_Y:      cfg_ff.focal_y <= csr_write_data[23:0];
            lpt_pkg::CSR_CENTER_X:     cfg_ff.center_x <= csr_write_data[23:0];
            lpt_pkg::CSR_CENTER_Y:     cfg_ff.center_y <= csr_write_data[23:0];
            lpt_pkg::CSR_PLANE_NX:     cfg_ff.plane_nx <= $signed(csr_write_data[31:0]);
            lpt_pkg::CSR_PLANE_NY:     cfg_ff.plane_ny <= $signed(csr_write_data[31:0]);
            lpt_pkg::CSR_PLANE_NZ:     cfg_ff.plane_nz <= $signed(csr_write_data[31:0]);
            lpt_pkg::CSR_PLANE_OFFSET: cfg_ff.plane_offset <= $signed(csr_write_data[47:0]);
            default: ;
         endcase
      end
   end

   // Front end and division chain.
   lpt_pkg::div_type chain [STEPS+1];

   lpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .div_out   (chain[0])
   );

   for (genvar i = 0; i < STEPS; i++) begin : g_div
      lpt_div_step u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .div_in  (chain[i]),
         .div_out (chain[i+1])
      );
   end

   // Result stage: sign, clamping and status. A quotient flagged big already
   // exceeds the 48-bit range, so it always clamps.
   lpt_pkg::div_type          fin;
   logic [lpt_pkg::QUO_W-1:0] quo [lpt_pkg::LANES];
   logic                      nonzero [lpt_pkg::LANES];
   logic                      negative [lpt_pkg::LANES];
   logic                      sat [lpt_pkg::LANES];
   logic [lpt_pkg::QUO_W-1:0] val [lpt_pkg::LANES];
   logic                      behind;

   always_comb begin
      fin = chain[STEPS];
      for (int k = 0; k < lpt_pkg::LANES; k++) begin
         quo[k] = fin.lane[k].sh;
         nonzero[k] = fin.lane[k].big || (quo[k] != '0);
         negative[k] = nonzero[k] && fin.lane[k].flip;
         if (negative[k]) begin
            sat[k] = fin.lane[k].big || (quo[k] > lpt_pkg::LIM_NEG);
            val[k] = sat[k] ? lpt_pkg::LIM_NEG : (~quo[k] + 1'b1);
         end else begin
            sat[k] = fin.lane[k].big || (quo[k] > lpt_pkg::LIM_POS);
            val[k] = sat[k] ? lpt_pkg::LIM_POS : quo[k];
         end
      end
      behind = negative[lpt_pkg::LANE_Z] || !nonzero[lpt_pkg::LANE_Z];
      rsp_data_in.point_x = $signed(val[lpt_pkg::LANE_X]);
      rsp_data_in.point_y = $signed(val[lpt_pkg::LANE_Y]);
      rsp_data_in.point_z = $signed(val[lpt_pkg::LANE_Z]);
      if (fin.dzero) begin
         rsp_data_in.status = lpt_pkg::STATUS_PARALLEL;
      end else if (behind) begin
         rsp_data_in.status = lpt_pkg::STATUS_BEHIND;
      end else if (sat[lpt_pkg::LANE_X] || sat[lpt_pkg::LANE_Y] || sat[lpt_pkg::LANE_Z]) begin
         rsp_data_in.status = lpt_pkg::STATUS_SATURATED;
      end else begin
         rsp_data_in.status = lpt_pkg::STATUS_VALID;
      end
      // Parallel and behind results carry zero coordinates.
      if (fin.dzero || behind) begin
         rsp_data_in.point_x = '0;
         rsp_data_in.point_y = '0;
         rsp_data_in.point_z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fin.valid;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

[tb/laser_plane_triangulation_checker.sv]
// Checker for the triangulation unit: tracks registers, predicts each response and compares.
module laser_plane_triangulation_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  lpt_pkg::req_type                req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  lpt_pkg::rsp_type                rsp_data,
   input  logic                            csr_write_enable,
   input  logic [lpt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lpt_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              failures,
   output int                              outstanding
);

   typedef logic signed [191:0] wide_type;

   lpt_pkg::cfg_type regs;
   lpt_pkg::rsp_type points_due[$];

   function automatic lpt_pkg::cfg_type reset_regs();
      lpt_pkg::cfg_type c;
      c.focal_x = 24'd262144;
      c.focal_y = 24'd262144;
      c.center_x = 24'd163840;
      c.center_y = 24'd122880;
      c.plane_nx = '0;
      c.plane_ny = '0;
      c.plane_nz = 32'sd1073741824;
      c.plane_offset = '0;
      return c;
   endfunction

   // One coordinate: -D*m*2^30/den truncated toward zero, clamped to 48 bits.
   function automatic logic signed [47:0] project(wide_type m, wide_type den, wide_type d,
                                                  output logic sat, output logic positive);
      wide_type q;
      q = ((-d * m) <<< 30) / den;
      positive = q > 0;
      sat = 1'b0;
      if (q > wide_type'(lpt_pkg::LIM_POS)) begin
         sat = 1'b1;
         return lpt_pkg::LIM_POS;
      end
      if (q < -(wide_type'(1) <<< 47)) begin
         sat = 1'b1;
         return lpt_pkg::LIM_NEG;
      end
      return q[47:0];
   endfunction

   function automatic lpt_pkg::rsp_type triangulate(lpt_pkg::cfg_type c, lpt_pkg::req_type r);
      wide_type dx, dy, fx, fy, mx, my, mz, den, d, nx, ny, nz;
      logic sx, sy, sz, px, py, pz;
      lpt_pkg::rsp_type o;
      fx = c.focal_x;
      fy = c.focal_y;
      dx = wide_type'(r.pixel_col) - wide_type'(c.center_x);
      dy = wide_type'(r.pixel_row) - wide_type'(c.center_y);
      nx = c.plane_nx;
      ny = c.plane_ny;
      nz = c.plane_nz;
      d = c.plane_offset;
      mx = dx * fy;
      my = dy * fx;
      mz = fx * fy;
      den = nx * mx + ny * my + nz * mz;
      o = '0;
      if (den == 0) begin
         o.status = lpt_pkg::STATUS_PARALLEL;
         return o;
      end
      o.point_z = project(mz, den, d, sz, pz);
      if (!pz) begin
         o.status = lpt_pkg::STATUS_BEHIND;
         o.point_z = '0;
         return o;
      end
      o.point_x = project(mx, den, d, sx, px);
      o.point_y = project(my, den, d, sy, py);
      o.status = (sx || sy || sz) ? lpt_pkg::STATUS_SATURATED : lpt_pkg::STATUS_VALID;
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
      failures++;
   endtask

   always @(posedge clock) begin
      lpt_pkg::rsp_type want;
      if (reset) begin
         regs <= reset_regs();
         points_due.delete();
         failures = 0;
         outstanding <= 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               lpt_pkg::CSR_FOCAL_X:      regs.focal_x <= csr_write_data[23:0];
               lpt_pkg::CSR_FOCAL_Y:      regs.focal_y <= csr_write_data[23:0];
               lpt_pkg::CSR_CENTER_X:     regs.center_x <= csr_write_data[23:0];
               lpt_pkg::CSR_CENTER_Y:     regs.center_y <= csr_write_data[23:0];
               lpt_pkg::CSR_PLANE_NX:     regs.plane_nx <= csr_write_data[31:0];
               lpt_pkg::CSR_PLANE_NY:     regs.plane_ny <= csr_write_data[31:0];
               lpt_pkg::CSR_PLANE_NZ:     regs.plane_nz <= csr_write_data[31:0];
               lpt_pkg::CSR_PLANE_OFFSET: regs.plane_offset <= csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            points_due.insert(points_due.size(), triangulate(regs, req_data));
         if (rsp_valid && !rsp_stall) begin
            if (points_due.size() == 0) begin
               report_mismatch("unexpected response", '0, '0);
            end else begin
               want = points_due.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 48'(rsp_data.status), 48'(want.status));
               if (rsp_data.point_x !== want.point_x)
                  report_mismatch("point_x", rsp_data.point_x, want.point_x);
               if (rsp_data.point_y !== want.point_y)
                  report_mismatch("point_y", rsp_data.point_y, want.point_y);
               if (rsp_data.point_z !== want.point_z)
                  report_mismatch("point_z", rsp_data.point_z, want.point_z);
            end
         end
         outstanding <= points_due.size();
      end
   end

endmodule

[tb/laser_plane_triangulation_unit_test.sv]
// Testbench top for the triangulation unit: clock, reset, stimulus and verdict.
module laser_plane_triangulation_unit_test;

   // Draining waits on past the depth of the unit to give a little margin.
   localparam int DRAIN_CYCLES = 70;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 180;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   lpt_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   lpt_pkg::rsp_type                rsp_data;
   logic                            csr_write_enable;
   logic [lpt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [lpt_pkg::CSR_DATA_W-1:0]  csr_write_data;
   int                              failures;
   int                              outstanding;
   int                              send_idle_pct;
   int                              recv_idle_pct;
   int                              requests_sent;

   laser_plane_triangulation_unit DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   laser_plane_triangulation_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures), .outstanding(outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random; the rate changes at phases 3 and 6.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Safety net in case the pipeline hangs.
   initial begin
      #20_000_000;
      $display("timeout waiting for responses");
      $display("FAILED: results differ");
      $finish;
   end

   // One register write per cycle; the enable is lowered by the caller.
   task automatic write_reg(logic [lpt_pkg::CSR_INDEX_W-1:0] idx,
                            logic [lpt_pkg::CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic load_setup(logic [23:0] fx, logic [23:0] fy, logic [23:0] cx,
                             logic [23:0] cy, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz, logic [47:0] offset);
      write_reg(lpt_pkg::CSR_FOCAL_X, 48'(fx));
      write_reg(lpt_pkg::CSR_FOCAL_Y, 48'(fy));
      write_reg(lpt_pkg::CSR_CENTER_X, 48'(cx));
      write_reg(lpt_pkg::CSR_CENTER_Y, 48'(cy));
      write_reg(lpt_pkg::CSR_PLANE_NX, {{16{nx[31]}}, nx});
      write_reg(lpt_pkg::CSR_PLANE_NY, {{16{ny[31]}}, ny});
      write_reg(lpt_pkg::CSR_PLANE_NZ, {{16{nz[31]}}, nz});
      write_reg(lpt_pkg::CSR_PLANE_OFFSET, offset);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every request has its response, then lets the pipe settle.
   task automatic wait_for_drain();
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Presents one request and holds it until the unit takes it. The valid is
   // left high for back-to-back requests unless the sender decides to idle.
   task automatic send_point(logic [23:0] col, logic [23:0] row);
      req_valid <= 1'b1;
      req_data <= '{pixel_col: col, pixel_row: row};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Mostly points near the principal point, where results tend to be valid,
   // plus full-range noise so every input bit toggles.
   task automatic send_random_point(logic [23:0] cx, logic [23:0] cy);
      if ($urandom_range(2) == 0)
         send_point(24'($urandom), 24'($urandom));
      else
         send_point(cx + 24'($urandom_range(0, 40000)) - 24'd20000,
                    cy + 24'($urandom_range(0, 40000)) - 24'd20000);
   endtask

   initial begin
      logic [23:0] fx, fy, cx, cy;
      logic [31:0] nx, ny, nz;
      logic [47:0] offset;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      send_idle_pct = 25;
      recv_idle_pct = 49;
      requests_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With reset registers the offset is zero, so everything lands behind.
      send_point(24'd163840, 24'd122880);
      send_point(24'd0, 24'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 25;
         end else if (phase == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         req_valid <= 1'b0;
         wait_for_drain();
         case (phase)
            0: begin
               // Plane facing the camera one meter out: regular points.
               fx = 24'd262144; fy = 24'd262144; cx = 24'd163840; cy = 24'd122880;
               nx = 32'd0; ny = 32'd0; nz = 32'sh4000_0000;
               offset = -48'sd65536;
            end
            1: begin
               // Normal along X only: the ray through the center column is parallel.
               fx = 24'hFF_FFFF; fy = 24'd256; cx = 24'h7F_FFFF; cy = 24'd0;
               nx = 32'sh4000_0000; ny = 32'd0; nz = 32'd0;
               offset = 48'sh7FFF_FFFF_FFFF;
            end
            2: begin
               // Smallest focal length and the largest offset force saturation.
               fx = 24'd256; fy = 24'd256; cx = 24'd0; cy = 24'hFF_FFFF;
               nx = 32'sh8000_0000; ny = 32'sh7FFF_FFFF; nz = 32'sd1;
               offset = 48'sh8000_0000_0000;
            end
            3: begin
               // Zero focal length is out of range but still defined.
               fx = 24'd0; fy = 24'd0; cx = 24'hFF_FFFF; cy = 24'hFF_FFFF;
               nx = 32'd0; ny = 32'sh4000_0000; nz = 32'sh7FFF_FFFF;
               offset = -48'sd1;
            end
            default: begin
               fx = 24'($urandom_range(256, 24'hFF_FFFF));
               fy = ($urandom_range(1)) ? fx : 24'($urandom_range(256, 24'hFF_FFFF));
               cx = 24'($urandom);
               cy = 24'($urandom);
               nx = $signed(32'($urandom)) >>> $urandom_range(0, 31);
               ny = $signed(32'($urandom)) >>> $urandom_range(0, 31);
               nz = $urandom_range(1) ? 32'sh4000_0000 : 32'($urandom);
               offset = $signed({16'($urandom), 32'($urandom)}) >>> $urandom_range(0, 47);
            end
         endcase
         load_setup(fx, fy, cx, cy, nx, ny, nz, offset);

         if (phase < 4) begin
            // Field extremes and the principal point itself.
            send_point(24'd0, 24'd0);
            send_point(24'hFF_FFFF, 24'hFF_FFFF);
            send_point(24'd0, 24'hFF_FFFF);
            send_point(24'hFF_FFFF, 24'd0);
            send_point(cx, cy);
            send_point(cx + 24'd1, cy - 24'd1);
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Once, hold off the sender until the pipeline has fully emptied.
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (outstanding != 0) @(posedge clock);
            end
            send_random_point(cx, cy);
         end
      end

      req_valid <= 1'b0;
      wait_for_drain();
      $display("Sent %0d requests across %0d plane and intrinsics setups,", requests_sent,
               PHASES);
      $display("with sender and receiver idling in turn and at full rate.");
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
